/* hw/rtl/sorted_priority_queue_macros.svh */
// Assertion macros shared by the sorted priority queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sorted_priority_queue: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sorted_priority_queue: assertion failed");

`endif

/* hw/rtl/spq_pkg.sv */
// Types, constants and index helpers for the sorted priority queue.
// No dependencies; imported by spq_ram and sorted_priority_queue.
package spq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int VAL_W   = 32;
	localparam int PRIO_W  = 8;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	// stream payload widths, padded to whole bytes
	localparam int IN_W  = 48;
	localparam int OUT_W = 56;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_FIND    = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ,
		S_DEQ,
		S_FIND,
		S_RESP
	} state_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [PRIO_W-1:0]       prio;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} ram_wr_t;

	// ring index step forward, wrapping at DEPTH
	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(i + 1'b1);
	endfunction

	// ring index step back, wrapping at zero
	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(i - 1'b1);
	endfunction

endpackage

/* hw/rtl/spq_ram.sv */
// Entry store of the queue: one write port, one registered read port.
// Depends on spq_pkg.
module spq_ram (
	input  logic                    clk,
	input  spq_pkg::ram_wr_t        wr,
	input  logic [spq_pkg::IDX_W-1:0] rd_addr,
	output spq_pkg::entry_t         rd_data
);
	import spq_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// From accept to result valid, clear and any rejected operation pass from S_IDLE to S_RESP; a
// dequeue passes through S_DEQ, an enqueue stays in S_ENQ while it moves held entries, a find in S_FIND until it stops.
// Throughput: one operation at a time; the next is taken once the result register is loaded.
// Work rate is one entry per cycle through the write port and registered read port of the entry store.
// Reset (arst_n low, asynchronous) empties the queue and drops any pending result.
// Sorted priority queue top level; depends on spq_pkg, spq_ram and the assertion macros.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	// operation [1:0], item_value [33:2], item_priority [41:34], zero padding above
	input  logic [spq_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// status [1:0], out_value [33:2], out_priority [41:34], position [45:42],
	// entry_count [50:46], zero padding above
	output logic [spq_pkg::OUT_W-1:0] m_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready
);
	import spq_pkg::*;

	// Entries live in a ring inside spq_ram, head at head_q, next free slot at tail_q.
	// Enqueue walks backwards from the tail one entry a cycle, moving each larger-numbered
	// entry up by one slot, then drops the new pair into the gap. Find walks forwards from
	// the head. Dequeue reads the head and advances it, so no entries move.

	state_t state_q, state_d;

	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0] count_q, count_d;

	// walk pointer (physical slot) and walk counter (logical position or entries left)
	logic [IDX_W-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0] k_q, k_d;

	// transaction being worked on
	logic signed [VAL_W-1:0] val_q, val_d;
	logic [PRIO_W-1:0]       prio_q, prio_d;

	// result waiting for the output register
	status_t                 res_status_q, res_status_d;
	logic signed [VAL_W-1:0] res_value_q, res_value_d;
	logic [PRIO_W-1:0]       res_prio_q, res_prio_d;
	logic [POS_W-1:0]        res_pos_q, res_pos_d;

	logic             m_valid_q, m_valid_d;
	logic [OUT_W-1:0] m_data_q, m_data_d;

	ram_wr_t          ram_wr;
	logic [IDX_W-1:0] ram_rd_addr;
	entry_t           ram_rd;

	op_t              in_op;
	logic             in_accept;
	logic             out_free;

	spq_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd)
	);

	assign in_op     = op_t'(s_axis_tdata[1:0]);
	assign in_accept = s_axis_tvalid && s_axis_tready;
	// the output register is free when empty or being drained this cycle
	assign out_free  = !m_valid_q || m_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		tail_d       = tail_q;
		count_d      = count_q;
		ptr_d        = ptr_q;
		k_d          = k_q;
		val_d        = val_q;
		prio_d       = prio_q;
		res_status_d = res_status_q;
		res_value_d  = res_value_q;
		res_prio_d   = res_prio_q;
		res_pos_d    = res_pos_q;
		m_data_d     = m_data_q;
		m_valid_d    = m_valid_q && !m_axis_tready;
		ram_wr       = '0;
		ram_rd_addr  = head_q;
		s_axis_tready = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				// prefetch the entry the chosen walk starts on
				ram_rd_addr = (in_op == OP_ENQUEUE) ? idx_dec(tail_q) : head_q;
				if (s_axis_tvalid) begin
					val_d        = s_axis_tdata[33:2];
					prio_d       = s_axis_tdata[41:34];
					res_status_d = ST_OK;
					res_value_d  = '0;
					res_prio_d   = '0;
					res_pos_d    = '0;
					unique case (in_op)
						OP_ENQUEUE: begin
							if (count_q == CNT_W'(DEPTH)) begin
								res_status_d = ST_FULL;
								state_d      = S_RESP;
							end else begin
								ptr_d   = tail_q;
								k_d     = count_q;
								state_d = S_ENQ;
							end
						end
						OP_DEQUEUE: begin
							if (count_q == '0) begin
								res_status_d = ST_EMPTY;
								state_d      = S_RESP;
							end else begin
								state_d = S_DEQ;
							end
						end
						OP_FIND: begin
							if (count_q == '0) begin
								res_status_d = ST_EMPTY;
								state_d      = S_RESP;
							end else begin
								ptr_d   = head_q;
								k_d     = '0;
								state_d = S_FIND;
							end
						end
						OP_CLEAR: begin
							count_d = '0;
							tail_d  = head_q;
							state_d = S_RESP;
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end

			S_ENQ: begin
				// ram_rd holds the entry just below ptr_q; fetch the one below that
				ram_rd_addr = idx_dec(idx_dec(ptr_q));
				if (k_q != '0 && ram_rd.prio > prio_q) begin
					ram_wr.en   = 1'b1;
					ram_wr.addr = ptr_q;
					ram_wr.data = ram_rd;
					ptr_d       = idx_dec(ptr_q);
					k_d         = CNT_W'(k_q - 1'b1);
				end else begin
					ram_wr.en         = 1'b1;
					ram_wr.addr       = ptr_q;
					ram_wr.data.value = val_q;
					ram_wr.data.prio  = prio_q;
					tail_d            = idx_inc(tail_q);
					count_d           = CNT_W'(count_q + 1'b1);
					state_d           = S_RESP;
				end
			end

			S_DEQ: begin
				res_value_d = ram_rd.value;
				res_prio_d  = ram_rd.prio;
				head_d      = idx_inc(head_q);
				count_d     = CNT_W'(count_q - 1'b1);
				state_d     = S_RESP;
			end

			S_FIND: begin
				// compare the entry at ptr_q while fetching the next one
				ram_rd_addr = idx_inc(ptr_q);
				if (ram_rd.value == val_q && ram_rd.prio == prio_q) begin
					res_pos_d = POS_W'(k_q);
					state_d   = S_RESP;
				end else if (CNT_W'(k_q + 1'b1) == count_q) begin
					res_status_d = ST_NOTFOUND;
					state_d      = S_RESP;
				end else begin
					ptr_d = idx_inc(ptr_q);
					k_d   = CNT_W'(k_q + 1'b1);
				end
			end

			S_RESP: begin
				// hold the result until the output register can take it
				if (out_free) begin
					m_valid_d = 1'b1;
					m_data_d  = {(OUT_W - 51)'(0), COUNT_W'(count_q), res_pos_q,
						res_prio_q, res_value_q, res_status_q};
					state_d   = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			m_valid_q <= m_valid_d;
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		ptr_q        <= ptr_d;
		k_q          <= k_d;
		val_q        <= val_d;
		prio_q       <= prio_d;
		res_status_q <= res_status_d;
		res_value_q  <= res_value_d;
		res_prio_q   <= res_prio_d;
		res_pos_q    <= res_pos_d;
		m_data_q     <= m_data_d;
	end

	// the fill count never passes the depth
	`SPQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	// the store is only written while an enqueue walks
	`SPQ_ASSERT_IMP(a_wr_in_enq, clk, arst_n, ram_wr.en, state_q == S_ENQ)
	// a clear empties the queue at once
	`SPQ_ASSERT_NXT(a_clear_empties, clk, arst_n, in_accept && in_op == OP_CLEAR,
		count_q == '0)
	// a dequeue on an empty queue goes straight to the response
	`SPQ_ASSERT_NXT(a_deq_empty, clk, arst_n,
		in_accept && in_op == OP_DEQUEUE && count_q == '0, state_q == S_RESP)
	// a new result only appears out of the response state
	`SPQ_ASSERT_IMP(a_result_source, clk, arst_n, $rose(m_valid_q),
		$past(state_q) == S_RESP)

endmodule
